// File: rtl/glmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glmd_pkg
// Shared types, constants and helpers of the grid local maximum detector.
// ----------------------------------------------------------------------------
package glmd_pkg;

	// Field widths
	localparam int CFG_W       = 11;
	localparam int DATA_W      = 32;
	localparam int POS_W       = 11;
	localparam int NUM_W       = 20;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 48;

	localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

	// Default sizes
	localparam int DEF_MAX_COLS = 1024;
	localparam int DEF_MAX_ROWS = 1024;
	localparam int QUEUE_DEPTH  = 4;

	// Register indexes
	localparam logic [1:0] REG_GRID_ROWS  = 2'd0;
	localparam logic [1:0] REG_GRID_COLS  = 2'd1;
	localparam logic [1:0] REG_TARGET_ROW = 2'd2;
	localparam logic [1:0] REG_TARGET_COL = 2'd3;

	// Input op codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_PAD    = 1'b1;

	// Result kinds
	localparam logic KIND_PEAK    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// One classified input item: up to two peaks and a summary
	typedef struct packed {
		logic             p1;
		logic             p2;
		logic             sum;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col1;
		logic [POS_W-1:0] col2;
		logic [NUM_W-1:0] num1;
		logic [NUM_W-1:0] num2;
		logic [NUM_W-1:0] total;
		logic             hit;
	} glmd_rec_t;

	// Saturating increment of the peak count
	function automatic logic [NUM_W-1:0] sat_inc(input logic [NUM_W-1:0] v);
		sat_inc = (v == NUM_MAX) ? v : v + NUM_W'(1);
	endfunction

endpackage : glmd_pkg
`default_nettype wire

// File: rtl/glmd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glmd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module glmd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read-first: a read at the write address returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule : glmd_ram
`default_nettype wire

// File: rtl/glmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glmd_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module glmd_queue #(
	parameter int DEPTH = glmd_pkg::QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire glmd_pkg::glmd_rec_t din,
	output logic                     full,
	input  wire logic                pop,
	output glmd_pkg::glmd_rec_t      dout,
	output logic                     valid
);
	import glmd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	glmd_rec_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [NW-1:0]   cnt_q;

	assign full  = (cnt_q == NW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid) else $error("queue read while empty");

endmodule : glmd_queue
`default_nettype wire

// File: rtl/glmd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glmd_back
// Expands each classified item into its result transactions, in order.
// ----------------------------------------------------------------------------
module glmd_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire glmd_pkg::glmd_rec_t rec,
	input  wire logic                q_valid,
	output logic                     q_pop,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic                     m_tuser,  // kind
	output logic                     m_tlast,  // last
	// peak_row[10:0], peak_col[21:11], peak_number[41:22], target_hit[42]
	output logic [glmd_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import glmd_pkg::*;

	glmd_rec_t  rec_q;
	logic [2:0] pend_q;   // {summary, second peak, first peak}
	logic [2:0] cur;
	logic [2:0] rest;
	logic       m_acc;

	logic [POS_W-1:0] f_row;
	logic [POS_W-1:0] f_col;
	logic [NUM_W-1:0] f_num;
	logic             f_hit;

	// Lowest pending result goes out first
	always_comb begin
		priority if (pend_q[0]) begin
			cur = 3'b001;
		end else if (pend_q[1]) begin
			cur = 3'b010;
		end else if (pend_q[2]) begin
			cur = 3'b100;
		end else begin
			cur = 3'b000;
		end
	end

	assign rest  = pend_q & ~cur;
	assign m_acc = m_tvalid && m_tready;
	assign q_pop = q_valid && ((pend_q == 3'b000) || (m_acc && (rest == 3'b000)));

	// Pending mask and held item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'b000;
		end else if (q_pop) begin
			pend_q <= {rec.sum, rec.p2, rec.p1};
		end else if (m_acc) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rec_q <= rec;
		end
	end

	// Result fields
	always_comb begin
		f_row   = rec_q.row;
		f_col   = rec_q.col1;
		f_num   = rec_q.num1;
		f_hit   = 1'b0;
		m_tuser = KIND_PEAK;
		if (cur[1]) begin
			f_col = rec_q.col2;
			f_num = rec_q.num2;
		end else if (cur[2]) begin
			f_row   = '0;
			f_col   = '0;
			f_num   = rec_q.total;
			f_hit   = rec_q.hit;
			m_tuser = KIND_SUMMARY;
		end
	end

	assign m_tvalid = (pend_q != 3'b000);
	assign m_tlast  = (rest == 3'b000);
	assign m_tdata  = {(OUT_TDATA_W - 1 - NUM_W - 2 * POS_W)'(0), f_hit, f_num, f_col, f_row};

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_SUMMARY)) |-> m_tlast)
		else $error("summary not marked last");

endmodule : glmd_back
`default_nettype wire

// File: rtl/glmd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glmd_front
// Accepts samples, keeps line buffers and the 3x3 window, and classifies
// every item into peak and summary results for the queue.
// ----------------------------------------------------------------------------
module glmd_front #(
	parameter int MAX_COLS = glmd_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = glmd_pkg::DEF_MAX_ROWS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [glmd_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic                        s_tuser,  // op
	input  wire logic [glmd_pkg::IN_TDATA_W-1:0] s_tdata, // sample[31:0]
	output glmd_pkg::glmd_rec_t              rec,
	output logic                             rec_push,
	input  wire logic                        q_full
);
	import glmd_pkg::*;

	localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CW  = $clog2(MAX_COLS + 1);
	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int CXW = (CW > CFG_W) ? CW : CFG_W;
	localparam int RXW = (RW > CFG_W) ? RW : CFG_W;
	localparam int LW  = 2 * DATA_W;

	// Configuration
	logic [CFG_W-1:0] rows_q, cols_q, trow_q, tcol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_W'(1);
			cols_q <= CFG_W'(1);
			trow_q <= CFG_W'(1);
			tcol_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_ROWS:  rows_q <= cfg_data;
				REG_GRID_COLS:  cols_q <= cfg_data;
				REG_TARGET_ROW: trow_q <= cfg_data;
				REG_TARGET_COL: tcol_q <= cfg_data;
				default:        rows_q <= rows_q;
			endcase
		end
	end

	// Clamp grid sizes to the buffer limits
	logic [RXW-1:0] rows_x, rows_lim;
	logic [CXW-1:0] cols_x, cols_lim;

	assign rows_x   = RXW'(rows_q);
	assign cols_x   = CXW'(cols_q);
	assign rows_lim = (rows_x == '0) ? RXW'(1) :
	                  (rows_x > RXW'(MAX_ROWS)) ? RXW'(MAX_ROWS) : rows_x;
	assign cols_lim = (cols_x == '0) ? CXW'(1) :
	                  (cols_x > CXW'(MAX_COLS)) ? CXW'(MAX_COLS) : cols_x;

	// Line buffer clearing after reset
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(MAX_COLS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Pipeline handshake
	logic v1_q, v2_q, v3_q;
	logic acc, adv1, adv2, adv3, free1, free2, free3;
	logic any3;

	assign adv3     = v3_q && (!any3 || !q_full);
	assign free3    = !v3_q || adv3;
	assign adv2     = v2_q && free3;
	assign free2    = !v2_q || adv2;
	assign adv1     = v1_q && free2;
	assign free1    = !v1_q || adv1;
	assign s_tready = !clr_busy_q && free1;
	assign acc      = s_tvalid && s_tready;

	// Stream position
	logic [AW-1:0] c_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_plus;
	logic          row_end, frame_end;

	assign c_plus    = CW'(c_q) + CW'(1);
	assign row_end   = (CXW'(c_plus) >= cols_lim);
	assign frame_end = row_end && (RXW'(r_q) >= rows_lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
		end else if (acc) begin
			if (row_end) begin
				c_q <= '0;
				r_q <= frame_end ? '0 : r_q + RW'(1);
			end else begin
				c_q <= c_q + AW'(1);
			end
		end
	end

	// Stage 1: item with line buffer read in flight
	logic signed [DATA_W-1:0] x_s1;
	logic [AW-1:0]            c_s1;
	logic [RW-1:0]            r_s1;
	logic                     chk1_s1, chk2_s1, sum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (acc) begin
			v1_q <= 1'b1;
		end else if (adv1) begin
			v1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1    <= (s_tuser == OP_PAD) ? '0 : s_tdata;
			c_s1    <= c_q;
			r_s1    <= r_q;
			chk1_s1 <= (r_q != '0) && (c_q != '0);
			chk2_s1 <= row_end && (r_q != '0);
			sum_s1  <= frame_end;
		end
	end

	// Line buffers: {older, newer} per column, with bypass of a same-cycle write
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [LW-1:0] ram_wdata, ram_rdata, line;
	logic          fwd_q;
	logic [LW-1:0] fwd_d_q;
	logic signed [DATA_W-1:0] older_rd, newer_rd, top, mid;

	assign line     = fwd_q ? fwd_d_q : ram_rdata;
	assign older_rd = line[LW-1:DATA_W];
	assign newer_rd = line[DATA_W-1:0];
	assign top      = (r_s1 >= RW'(2)) ? older_rd : '0;
	assign mid      = (r_s1 != '0) ? newer_rd : '0;

	assign ram_we    = clr_busy_q || adv1;
	assign ram_waddr = clr_busy_q ? clr_addr_q : c_s1;
	assign ram_wdata = clr_busy_q ? '0 : {newer_rd, x_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (acc) begin
			fwd_q <= adv1 && (c_q == c_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			fwd_d_q <= ram_wdata;
		end
	end

	glmd_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_COLS)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (acc),
		.raddr (c_q),
		.rdata (ram_rdata)
	);

	// Stage 2: 3x3 window, [row][col], col 2 newest
	logic signed [DATA_W-1:0] win_s2 [3][3];
	logic [AW-1:0]            c_s2;
	logic [RW-1:0]            r_s2;
	logic                     chk1_s2, chk2_s2, sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (adv1) begin
			v2_q <= 1'b1;
		end else if (adv2) begin
			v2_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int i = 0; i < 3; i++) begin
				win_s2[i][0] <= (c_s1 == '0) ? '0 : win_s2[i][1];
				win_s2[i][1] <= (c_s1 == '0) ? '0 : win_s2[i][2];
			end
			win_s2[0][2] <= top;
			win_s2[1][2] <= mid;
			win_s2[2][2] <= x_s1;
			c_s2    <= c_s1;
			r_s2    <= r_s1;
			chk1_s2 <= chk1_s1;
			chk2_s2 <= chk2_s1;
			sum_s2  <= sum_s1;
		end
	end

	// Strict maximum tests for the centre and, at row end, the right cell
	logic gt1, gt2;

	always_comb begin
		gt1 = 1'b1;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if ((i != 1 || j != 1) && !(win_s2[1][1] > win_s2[i][j])) begin
					gt1 = 1'b0;
				end
			end
		end
		gt2 = (win_s2[1][2] > win_s2[1][1]) && (win_s2[1][2] > 0);
		for (int i = 0; i < 3; i += 2) begin
			for (int j = 1; j < 3; j++) begin
				if (!(win_s2[1][2] > win_s2[i][j])) begin
					gt2 = 1'b0;
				end
			end
		end
	end

	// Stage 3: classified item
	logic          p1_s3, p2_s3, sum_s3;
	logic [AW-1:0] c_s3;
	logic [RW-1:0] r_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
		end else if (adv2) begin
			v3_q <= 1'b1;
		end else if (adv3) begin
			v3_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			p1_s3  <= chk1_s2 && gt1;
			p2_s3  <= chk2_s2 && gt2;
			sum_s3 <= sum_s2;
			c_s3   <= c_s2;
			r_s3   <= r_s2;
		end
	end

	// Peak numbering, target match and frame summary
	logic [NUM_W-1:0] cnt_q, num1, num2;
	logic             hit_q, hit_new, row_match;
	logic [CW-1:0]    c3_plus;
	logic [RXW-1:0]   row_x;
	logic [CXW-1:0]   col1_x, col2_x;

	assign any3      = p1_s3 || p2_s3 || sum_s3;
	assign c3_plus   = CW'(c_s3) + CW'(1);
	assign row_x     = RXW'(r_s3);
	assign col1_x    = CXW'(c_s3);
	assign col2_x    = CXW'(c3_plus);
	assign row_match = (row_x == RXW'(trow_q));
	assign num1      = p1_s3 ? sat_inc(cnt_q) : cnt_q;
	assign num2      = p2_s3 ? sat_inc(num1) : num1;
	assign hit_new   = hit_q
	                 || (p1_s3 && row_match && (col1_x == CXW'(tcol_q)))
	                 || (p2_s3 && row_match && (col2_x == CXW'(tcol_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			hit_q <= 1'b0;
		end else if (adv3) begin
			cnt_q <= sum_s3 ? '0 : num2;
			hit_q <= sum_s3 ? 1'b0 : hit_new;
		end
	end

	assign rec_push  = adv3 && any3;
	assign rec.p1    = p1_s3;
	assign rec.p2    = p2_s3;
	assign rec.sum   = sum_s3;
	assign rec.row   = row_x[POS_W-1:0];
	assign rec.col1  = col1_x[POS_W-1:0];
	assign rec.col2  = col2_x[POS_W-1:0];
	assign rec.num1  = num1;
	assign rec.num2  = num2;
	assign rec.total = num2;
	assign rec.hit   = hit_new;

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_push && rec.sum) |=> ((cnt_q == '0) && !hit_q))
		else $error("frame state not cleared after summary");

	a_bypass_same_col: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && adv1 && (c_q == c_s1)) |=> fwd_q)
		else $error("line buffer bypass missed");

endmodule : glmd_front
`default_nettype wire

// File: rtl/grid_local_maximum_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_local_maximum_detector
// 3x3 strict local maximum detector over a raster-order grid stream.
//
// Input stream: one transaction per grid cell (tuser = op, tdata = sample),
// rows of grid_cols cells, then one padding row; the cell values outside the
// grid count as zero. Output stream: one transaction per peak (row, column,
// running ordinal) and an end-of-frame summary on the last padding item
// (peak total, target hit). tlast marks the final result of an input item.
// Throughput is one input transaction per clock while the queue has room:
// each item does one read and one write of the line buffer RAM at its column
// and one window update. Up to three results per item leave at one per clock
// from the back end while the receiver is ready; the queue between front and
// back absorbs bursts. An item is registered in the front stages, the queue
// and the back end before its first result. After reset the line buffer RAM
// is cleared, one column per cycle, over all MAX_COLS columns with s_tready
// low; configuration writes are taken as usual. A stalled receiver first
// fills the output stage and queue, then holds s_tready low; nothing is lost.
// ----------------------------------------------------------------------------
module grid_local_maximum_detector #(
	parameter int MAX_COLS = glmd_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = glmd_pkg::DEF_MAX_ROWS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [glmd_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic                            s_tuser,  // op
	input  wire logic [glmd_pkg::IN_TDATA_W-1:0] s_tdata,  // sample[31:0]
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic                                 m_tuser,  // kind
	output logic                                 m_tlast,  // last
	// peak_row[10:0], peak_col[21:11], peak_number[41:22], target_hit[42]
	output logic [glmd_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import glmd_pkg::*;

	glmd_rec_t front_rec, back_rec;
	logic      rec_push, q_full, q_valid, q_pop;

	glmd_front #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.rec       (front_rec),
		.rec_push  (rec_push),
		.q_full    (q_full)
	);

	glmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.din    (front_rec),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (back_rec),
		.valid  (q_valid)
	);

	glmd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec      (back_rec),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tdata  (m_tdata)
	);

endmodule : grid_local_maximum_detector
`default_nettype wire

// File: verif/grid_local_maximum_detector_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_local_maximum_detector_test
// Self-checking bench for the grid local maximum detector. A scoreboard runs
// its own model of the line buffers, the 3x3 window and the frame counters on
// every accepted input transaction, and checks the output stream against the
// peak reports and frame summaries it expects, in order. Stimulus covers hand
// built frames, a long receiver hold-off, random frames of small shapes, noisy
// and broken frames, and register changes part way through a frame. Both
// stream sides idle at random.
// ----------------------------------------------------------------------------
module grid_local_maximum_detector_test;
	import glmd_pkg::*;

	localparam int GRID_COLS_MAX  = DEF_MAX_COLS;
	localparam int GRID_ROWS_MAX  = DEF_MAX_ROWS;
	localparam int CFG_TOP        = (1 << CFG_W) - 1;
	localparam int SETTLE_CYCLES  = 16;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 160;
	localparam int REPORT_LIMIT   = 10;

	// One output transaction as the scoreboard expects it
	typedef struct packed {
		logic             kind;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [NUM_W-1:0] num;
		logic             hit;
		logic             last;
	} peak_report_t;

	typedef enum int {VAL_WIDE, VAL_NARROW, VAL_EXTREME, VAL_FLAT} value_style_t;
	typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_CHOKED} rx_mode_t;

	// ------------------------------------------------------------------------
	// Scoreboard: peak detector model plus the queue of awaited reports
	// ------------------------------------------------------------------------
	class peak_scoreboard;
		logic [CFG_W-1:0]  reg_rows, reg_cols, reg_trow, reg_tcol;
		logic [DATA_W-1:0] older_line [GRID_COLS_MAX];
		logic [DATA_W-1:0] newer_line [GRID_COLS_MAX];
		logic [DATA_W-1:0] win [3][3];
		int                row_pos, col_pos;
		logic [NUM_W-1:0]  peak_total;
		logic              target_seen;
		peak_report_t      awaited_reports [$];
		int                mismatches;

		function new();
			reg_rows = 1;
			reg_cols = 1;
			reg_trow = 1;
			reg_tcol = 1;
			for (int i = 0; i < GRID_COLS_MAX; i++) begin
				older_line[i] = '0;
				newer_line[i] = '0;
			end
			foreach (win[i, j]) win[i][j] = '0;
			row_pos = 0;
			col_pos = 0;
			peak_total = '0;
			target_seen = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
			REG_GRID_ROWS:  reg_rows = v;
			REG_GRID_COLS:  reg_cols = v;
			REG_TARGET_ROW: reg_trow = v;
			REG_TARGET_COL: reg_tcol = v;
			default: ;
			endcase
		endfunction

		function void shift_window(logic [DATA_W-1:0] top, logic [DATA_W-1:0] mid,
				logic [DATA_W-1:0] bot);
			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = top;
			win[1][2] = mid;
			win[2][2] = bot;
		endfunction

		// Centre must beat all eight neighbours, signed and strictly
		function void judge_centre(int r1, int c1);
			logic signed [DATA_W-1:0] centre;
			bit                       peak;
			peak_report_t             rep;
			centre = win[1][1];
			peak = 1'b1;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					if ((i != 1 || j != 1) && !(centre > $signed(win[i][j])))
						peak = 1'b0;
			if (!peak)
				return;
			if (peak_total != NUM_MAX)
				peak_total++;
			if (r1 == reg_trow && c1 == reg_tcol)
				target_seen = 1'b1;
			rep.kind = KIND_PEAK;
			rep.row  = POS_W'(r1);
			rep.col  = POS_W'(c1);
			rep.num  = peak_total;
			rep.hit  = 1'b0;
			rep.last = 1'b0;
			awaited_reports.push_back(rep);
		endfunction

		// Advance the model by one accepted input transaction
		function void note_cell(logic op, logic [DATA_W-1:0] smp);
			int                rows, cols, r, c, ci, first;
			logic [DATA_W-1:0] x, top, mid;
			peak_report_t      rep;
			rows = (reg_rows == 0) ? 1 : (reg_rows > GRID_ROWS_MAX) ? GRID_ROWS_MAX : reg_rows;
			cols = (reg_cols == 0) ? 1 : (reg_cols > GRID_COLS_MAX) ? GRID_COLS_MAX : reg_cols;
			r = row_pos;
			c = col_pos;
			ci = (c < GRID_COLS_MAX) ? c : GRID_COLS_MAX - 1;
			x = (op == OP_PAD) ? '0 : smp;
			first = awaited_reports.size();

			// rows above the grid read as zero
			top = (r >= 2) ? older_line[ci] : '0;
			mid = (r >= 1) ? newer_line[ci] : '0;
			if (c == 0)
				foreach (win[i, j]) win[i][j] = '0;
			shift_window(top, mid, x);
			older_line[ci] = newer_line[ci];
			newer_line[ci] = x;

			if (r >= 1 && c >= 1)
				judge_centre(r, c);

			// end of row: right border of zeros decides the last column
			if (c + 1 >= cols) begin
				shift_window('0, '0, '0);
				if (r >= 1)
					judge_centre(r, c + 1);
				col_pos = 0;
				if (r >= rows) begin
					rep.kind = KIND_SUMMARY;
					rep.row  = '0;
					rep.col  = '0;
					rep.num  = peak_total;
					rep.hit  = target_seen;
					rep.last = 1'b0;
					awaited_reports.push_back(rep);
					row_pos = 0;
					peak_total = '0;
					target_seen = 1'b0;
				end else begin
					row_pos = r + 1;
				end
			end else begin
				col_pos = c + 1;
			end

			if (awaited_reports.size() > first)
				awaited_reports[awaited_reports.size() - 1].last = 1'b1;
		endfunction

		// Compare one output transaction with the oldest awaited report
		function void check_report(logic kind, logic last, logic [OUT_TDATA_W-1:0] data);
			peak_report_t want;
			if (awaited_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("ERROR: %0t unexpected result kind %0d last %0d data %h",
						$realtime, kind, last, data);
				return;
			end
			want = awaited_reports.pop_front();
			// tdata: row[10:0] col[21:11] number[41:22] hit[42], rest zero
			if (kind !== want.kind || last !== want.last || data[10:0] !== want.row ||
					data[21:11] !== want.col || data[41:22] !== want.num ||
					data[42] !== want.hit || data[47:43] !== 5'b0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("ERROR: %0t expected kind %0d row %0d col %0d num %0d hit %0d last %0d",
						$realtime, want.kind, want.row, want.col, want.num, want.hit,
						want.last);
					$display("ERROR: %0t got kind %0d row %0d col %0d num %0d hit %0d last %0d pad %h",
						$realtime, kind, data[10:0], data[21:11], data[41:22], data[42],
						last, data[47:43]);
				end
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals and block under test
	// ------------------------------------------------------------------------
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [1:0]             cfg_index = REG_GRID_ROWS;
	logic [CFG_W-1:0]       cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic                   s_tuser   = OP_SAMPLE;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic                   m_tuser;
	logic                   m_tlast;
	logic [OUT_TDATA_W-1:0] m_tdata;

	peak_scoreboard sb;

	// sender state
	int burst_left = 0;
	bit steady     = 1'b0;
	int total_sent = 0;

	// receiver state
	logic     hold_token = 1'b0;
	logic     hold_seen  = 1'b0;
	int       hold_left  = 0;
	rx_mode_t rx_mode    = RX_OPEN;
	int       rx_left    = 0;
	int       rx_phase   = 0;
	bit       ready_next;

	grid_local_maximum_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.m_tdata   (m_tdata)
	);

	// 4 ns clock
	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Driving tasks
	// ------------------------------------------------------------------------

	// Offer one input transaction, with random gaps between bursts
	task automatic send_item(input logic op, input logic [DATA_W-1:0] smp);
		int gap;
		if (!steady && burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= smp;
		do begin
			@(posedge clk);
		end while (s_tready !== 1'b1);
		sb.note_cell(op, smp);
		total_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic write_one(input logic [1:0] idx, input logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	// All four registers on back-to-back edges
	task automatic set_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
			input logic [CFG_W-1:0] trow, input logic [CFG_W-1:0] tcol);
		write_one(REG_GRID_ROWS, rows);
		write_one(REG_GRID_COLS, cols);
		write_one(REG_TARGET_ROW, trow);
		write_one(REG_TARGET_COL, tcol);
		cfg_we <= 1'b0;
	endtask

	// Stop offering and wait until the block has drained
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.awaited_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	function automatic int clamp_size(input logic [CFG_W-1:0] v, input int top);
		return (v == 0) ? 1 : (v > top) ? top : int'(v);
	endfunction

	// Mostly inside the grid, sometimes zero or beyond it
	function automatic logic [CFG_W-1:0] pick_target(input int span);
		case ($urandom_range(0, 5))
		0: return '0;
		1: return CFG_W'($urandom_range(span + 1, CFG_TOP));
		default: return CFG_W'($urandom_range(1, span));
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_sample(input value_style_t style,
			input logic [DATA_W-1:0] flat);
		case (style)
		VAL_WIDE:   return $urandom;
		VAL_NARROW: return DATA_W'($urandom_range(0, 6)) - DATA_W'(3);
		VAL_EXTREME: begin
			case ($urandom_range(0, 4))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0001;
			default: return '0;
			endcase
		end
		default: return ($urandom_range(0, 9) == 0) ? flat + 1 : flat;
		endcase
	endfunction

	// One frame: grid rows then the padding row; cut >= 0 breaks it off early
	task automatic send_frame(input int rows, input int cols, input value_style_t style,
			input bit noisy, input int cut);
		int                sent;
		logic              op;
		logic [DATA_W-1:0] flat;
		sent = 0;
		flat = $urandom;
		for (int r = 0; r <= rows; r++) begin
			for (int c = 0; c < cols; c++) begin
				if (sent == cut)
					return;
				op = (r == rows) ? OP_PAD : OP_SAMPLE;
				if (noisy && $urandom_range(0, 7) == 0)
					op = (op == OP_PAD) ? OP_SAMPLE : OP_PAD;
				send_item(op, pick_sample(style, flat));
				sent++;
			end
		end
	endtask

	// Pad out whatever is left of the current frame
	task automatic realign();
		while (sb.row_pos != 0 || sb.col_pos != 0)
			send_item(OP_PAD, $urandom);
	endtask

	// ------------------------------------------------------------------------
	// Receiver: checks results and stalls on its own changing pattern
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_report(m_tuser, m_tlast, m_tdata);

		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(30, 200);
		end else begin
			rx_left--;
		end

		// long hold-off on request
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end

		if (hold_left > 0) begin
			hold_left--;
			ready_next = 1'b0;
		end else begin
			case (rx_mode)
			RX_OPEN:    ready_next = 1'b1;
			RX_RANDOM:  ready_next = ($urandom_range(0, 2) != 0);
			RX_PATTERN: ready_next = ((rx_phase % 5) >= 2);
			default:    ready_next = ($urandom_range(0, 4) == 0);
			endcase
		end
		rx_phase++;
		m_tready <= ready_next;
	end

	// ------------------------------------------------------------------------
	// Watchdog: too long without any transaction on either side
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		logic [CFG_W-1:0] rows_w, cols_w;
		int               rows_e, cols_e, start_items;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset shape 1x1 with the target on the only cell
		send_item(OP_SAMPLE, 32'h7FFF_FFFF);  // lone maximum, target hit
		send_item(OP_PAD, 32'h1234_5678);     // padding row, summary
		send_item(OP_SAMPLE, 32'h8000_0000);  // most negative cell
		send_item(OP_SAMPLE, 32'd5);          // sample landing in the padding row
		send_item(OP_PAD, 32'hFFFF_FFFF);     // padding tick used as a grid cell
		send_item(OP_PAD, 32'h0000_0000);
		settle();

		// 2x3 grid, target at row 2 column 2
		set_grid(11'd2, 11'd3, 11'd2, 11'd2);
		send_item(OP_SAMPLE, 32'h8000_0000);
		send_item(OP_SAMPLE, 32'd100);
		send_item(OP_PAD, 32'hFFFF_FFFF);
		send_item(OP_SAMPLE, 32'hFFFF_FFFF);
		send_item(OP_SAMPLE, 32'h7FFF_FFFF);
		send_item(OP_SAMPLE, 32'd1);
		send_item(OP_PAD, 32'h5555_5555);
		send_item(OP_SAMPLE, 32'd5);
		send_item(OP_PAD, 32'hAAAA_AAAA);
		settle();

		start_items = total_sent;

		// Receiver holds off while the sender keeps offering
		set_grid(11'd6, 11'd8, 11'd3, 11'd4);
		steady = 1'b1;
		hold_token <= ~hold_token;
		send_frame(6, 8, VAL_WIDE, 1'b0, -1);
		steady = 1'b0;
		settle();

		// Random frames of small shapes, some noisy, some broken off
		while (total_sent - start_items < RANDOM_ITEMS) begin
			rows_w = ($urandom_range(0, 9) == 0) ? '0 : CFG_W'($urandom_range(1, 6));
			cols_w = ($urandom_range(0, 9) == 0) ? '0 : CFG_W'($urandom_range(1, 8));
			rows_e = clamp_size(rows_w, GRID_ROWS_MAX);
			cols_e = clamp_size(cols_w, GRID_COLS_MAX);
			set_grid(rows_w, cols_w, pick_target(rows_e), pick_target(cols_e));
			steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3))
				send_frame(rows_e, cols_e, value_style_t'($urandom_range(0, 3)),
					$urandom_range(0, 3) == 0, -1);
			if ($urandom_range(0, 5) == 0) begin
				// break off mid-frame, then change the shape under it
				send_frame(rows_e, cols_e, VAL_WIDE, 1'b0,
					$urandom_range(1, rows_e * cols_e));
				settle();
				set_grid(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 8)),
					CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 8)));
				realign();
			end
			steady = 1'b0;
			settle();
		end

		if (sb.mismatches == 0 && sb.awaited_reports.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/glmd_pkg.sv
rtl/glmd_ram.sv
rtl/glmd_queue.sv
rtl/glmd_back.sv
rtl/glmd_front.sv
rtl/grid_local_maximum_detector.sv
verif/grid_local_maximum_detector_test.sv
